[rtl/core/cit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_pkg: shared types and constants of the coordinate id table
// Table geometry, field widths, the search token that walks the cell row,
// the broadcast write port and the controller state type.
// ----------------------------------------------------------------------------
package cit_pkg;

    // Table geometry
    localparam int DEPTH   = 256;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths
    localparam int IN_W    = 16;
    localparam int COORD_W = 16;
    localparam int ID_W    = 9;

    // Search token, one per cell stage
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CNT_W-1:0]   id;
    } cit_tok_t;

    // Broadcast write into one cell
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } cit_wr_t;

    // Segment bounds seen by every cell
    typedef struct packed {
        logic [CNT_W-1:0] seg_start;
        logic [CNT_W-1:0] fill;
    } cit_bounds_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } cit_state_t;

endpackage

[rtl/core/cit_coord_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_coord_if: input channel of the coordinate id table
// Valid/ready channel carrying a coordinate or a segment restart mark.
// ----------------------------------------------------------------------------
interface cit_coord_if
    import cit_pkg::*;
();

    logic                   valid;
    logic                   ready;
    logic                   start_segment;
    logic signed [IN_W-1:0] coord_x;
    logic signed [IN_W-1:0] coord_y;

    modport source (
        output valid,
        output start_segment,
        output coord_x,
        output coord_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_segment,
        input  coord_x,
        input  coord_y,
        output ready
    );

endinterface

[rtl/core/cit_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_result_if: result channel of the coordinate id table
// Valid/ready channel carrying the id and the insert/full flags.
// ----------------------------------------------------------------------------
interface cit_result_if
    import cit_pkg::*;
();

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] location_id;
    logic            was_inserted;
    logic            table_full;

    modport source (
        output valid,
        output location_id,
        output was_inserted,
        output table_full,
        input  ready
    );

    modport sink (
        input  valid,
        input  location_id,
        input  was_inserted,
        input  table_full,
        output ready
    );

endinterface

[rtl/core/cit_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_cell: one table entry of the coordinate id table
// Holds one stored coordinate, compares it against the passing search token
// and hands the token on to the next cell through its token register.
// ----------------------------------------------------------------------------
module cit_cell
    import cit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] index,
    input  cit_bounds_t      bounds,
    input  cit_wr_t          wr,
    input  cit_tok_t         tok_in,
    output cit_tok_t         tok_out
);

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               tok_valid_reg;
    cit_tok_t           tok_reg;
    cit_tok_t           tok_next;
    logic [CNT_W-1:0]   idx_ext;
    logic               live;
    logic               hit;

    // Entry is searched only inside the current segment
    assign idx_ext = CNT_W'(index);
    assign live    = (idx_ext >= bounds.seg_start) && (idx_ext < bounds.fill);
    assign hit     = live && (x_reg == tok_in.x) && (y_reg == tok_in.y);

    // Token update: first hit wins, id is the position inside the segment
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && hit)
        begin
            tok_next.found = 1'b1;
            tok_next.id    = idx_ext - bounds.seg_start + CNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == index))
        begin
            x_reg <= wr.x;
            y_reg <= wr.y;
        end
    end

    // Token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

[rtl/core/cit_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_ctrl: sequencer of the coordinate id table
// Accepts items, injects search tokens into the cell row, decides insert or
// hit when the token leaves the row, keeps the fill and segment pointers and
// drives the output register.
// ----------------------------------------------------------------------------
module cit_ctrl
    import cit_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cit_coord_if.sink    coord,
    cit_result_if.source result,
    output cit_tok_t     tok_head,
    input  cit_tok_t     tok_tail,
    output cit_wr_t      wr,
    output cit_bounds_t  bounds
);

    cit_state_t       state_reg;
    cit_state_t       state_next;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] seg_reg;
    logic [CNT_W-1:0] seg_next;

    logic [ID_W-1:0]  pend_id_reg;
    logic [ID_W-1:0]  pend_id_next;
    logic             pend_ins_reg;
    logic             pend_ins_next;
    logic             pend_full_reg;
    logic             pend_full_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ID_W-1:0]  out_id_reg;
    logic             out_ins_reg;
    logic             out_full_reg;

    logic             accept;
    logic             search_done;
    logic             has_room;
    logic             slot_free;
    logic             commit;

    // Handshake and event decode
    assign accept      = coord.valid && coord.ready;
    assign search_done = (state_reg == ST_SEARCH) && tok_tail.valid;
    assign has_room    = (fill_reg < CNT_W'(DEPTH));
    assign slot_free   = !out_valid_reg || result.ready;
    assign commit      = (state_reg == ST_COMMIT) && slot_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = coord.start_segment ? ST_COMMIT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok_tail.valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        coord.ready    = (state_reg == ST_IDLE);
        tok_head.valid = accept && !coord.start_segment;
        tok_head.found = 1'b0;
        tok_head.x     = COORD_W'(coord.coord_x);
        tok_head.y     = COORD_W'(coord.coord_y);
        tok_head.id    = '0;
    end

    // Insert on a miss with room left
    always_comb
    begin
        wr.en  = search_done && !tok_tail.found && has_room;
        wr.idx = fill_reg[IDX_W-1:0];
        wr.x   = tok_tail.x;
        wr.y   = tok_tail.y;
    end

    assign bounds.seg_start = seg_reg;
    assign bounds.fill      = fill_reg;

    // Pointers and pending result
    always_comb
    begin
        fill_next      = fill_reg;
        seg_next       = seg_reg;
        pend_id_next   = pend_id_reg;
        pend_ins_next  = pend_ins_reg;
        pend_full_next = pend_full_reg;
        if (accept && coord.start_segment)
        begin
            seg_next       = fill_reg;
            pend_id_next   = '0;
            pend_ins_next  = 1'b0;
            pend_full_next = 1'b0;
        end
        else if (search_done)
        begin
            if (tok_tail.found)
            begin
                pend_id_next   = ID_W'(tok_tail.id);
                pend_ins_next  = 1'b0;
                pend_full_next = 1'b0;
            end
            else if (has_room)
            begin
                fill_next      = fill_reg + CNT_W'(1);
                pend_id_next   = ID_W'(fill_reg - seg_reg + CNT_W'(1));
                pend_ins_next  = 1'b1;
                pend_full_next = 1'b0;
            end
            else
            begin
                pend_id_next   = '0;
                pend_ins_next  = 1'b0;
                pend_full_next = 1'b1;
            end
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        pend_ins_reg  <= pend_ins_next;
        pend_full_reg <= pend_full_next;
        if (commit)
        begin
            out_id_reg   <= pend_id_reg;
            out_ins_reg  <= pend_ins_reg;
            out_full_reg <= pend_full_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.location_id  = out_id_reg;
    assign result.was_inserted = out_ins_reg;
    assign result.table_full   = out_full_reg;

endmodule

[rtl/core/coordinate_id_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_id_table: lookup-or-insert table giving coordinates short ids
//
//   channel  | dir  | payload
//   ---------+------+-----------------------------------------------
//   coord    | sink | start_segment, coord_x, coord_y
//   result   | src  | location_id, was_inserted, table_full
//
// A lookup walks a search token down a row of DEPTH cells, one cell per
// cycle. Its result goes through the pending register and, once the output
// register is free, into it; only then is the next item taken. A restart
// skips the cell row and commits straight from the pending register.
// One item is in flight at a time.
// Reset clears the fill and segment pointers; entry storage is not cleared.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module coordinate_id_table
    import cit_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cit_coord_if.sink    coord,
    cit_result_if.source result
);

    cit_tok_t    tok [DEPTH+1];
    cit_wr_t     wr;
    cit_bounds_t bounds;

    // Sequencer
    cit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .coord    (coord),
        .result   (result),
        .tok_head (tok[0]),
        .tok_tail (tok[DEPTH]),
        .wr       (wr),
        .bounds   (bounds)
    );

    // Row of entry cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cit_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (IDX_W'(i)),
            .bounds  (bounds),
            .wr      (wr),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

endmodule
